FILE: rtl/ffs_pkg.sv
// Shared types and constants for the first-fit suballocator.
// Holds the request and result item structs, status and opcode codes.
// No dependencies.
`timescale 1ns / 1ps

package ffs_pkg;

    localparam int NODES_DEF  = 64;
    localparam int CHUNKS_DEF = 32;
    localparam int TYPES_DEF  = 32;

    localparam logic [32:0] CHUNK_SIZE_RST = 33'h0_0400_0000;
    localparam logic [32:0] CHUNK_SIZE_MAX = 33'h1_0000_0000;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_TRIM  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DEDIC   = 3'd1;
    localparam logic [2:0] ST_NOCHUNK = 3'd2;
    localparam logic [2:0] ST_NONODE  = 3'd3;
    localparam logic [2:0] ST_NOTPOOL = 3'd4;
    localparam logic [2:0] ST_REL     = 3'd5;
    localparam logic [2:0] ST_NOREL   = 3'd6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        resource_kind;
        logic [4:0]  memory_type;
        logic [39:0] request_size;
        logic [32:0] alignment;
        logic [4:0]  block_chunk;
        logic [31:0] block_offset;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  result_chunk;
        logic [31:0] result_offset;
        logic        new_chunk;
        logic        last;
    } t_rsp;

    function automatic t_rsp mk_rsp(input logic [2:0] status, input logic [4:0] chunk,
                                    input logic [31:0] offset, input logic new_chunk,
                                    input logic last);
        t_rsp r;
        r.status        = status;
        r.result_chunk  = chunk;
        r.result_offset = offset;
        r.new_chunk     = new_chunk;
        r.last          = last;
        return r;
    endfunction

endpackage

FILE: rtl/ffs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/first_fit_suballocator.sv
// First-fit suballocator: free-list sequencer over node and list-head RAMs.
// Depends on ffs_pkg and ffs_ram.
// An alloc walks the nodes of its list and, when none fits, scans the chunks for
// a free one to open; a free walks the list that owns the chunk; a trim walks every
// list and releases each node spanning a whole chunk. One item at a time; o_busy
// high meanwhile. After reset a clearing pass builds the spare chain and empties
// the list heads, with o_busy high. Results are one-cycle strobes; the receiver
// cannot stall.
`timescale 1ns / 1ps

module first_fit_suballocator #(
    parameter int NODES  = ffs_pkg::NODES_DEF,
    parameter int CHUNKS = ffs_pkg::CHUNKS_DEF,
    parameter int TYPES  = ffs_pkg::TYPES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  ffs_pkg::t_req i_req,
    output logic          o_result_valid,
    output ffs_pkg::t_rsp o_result,
    input  logic          i_cfg_we,
    input  logic [32:0]   i_cfg_wdata
);

    import ffs_pkg::*;

    localparam int LISTS = 2 * TYPES;
    localparam int AW    = $clog2(NODES);
    localparam int NW    = $clog2(NODES + 1);
    localparam int LW    = $clog2(LISTS);
    localparam int CW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int IC    = (NODES > LISTS) ? NODES : LISTS;
    localparam int ICW   = $clog2(IC);
    localparam logic [NW-1:0] NIL = NW'(NODES);

    localparam logic [5:0] S_INIT    = 6'd0;
    localparam logic [5:0] S_IDLE    = 6'd1;
    localparam logic [5:0] S_A_CHK   = 6'd2;
    localparam logic [5:0] S_A_HEAD  = 6'd3;
    localparam logic [5:0] S_A_WALK  = 6'd4;
    localparam logic [5:0] S_A_NODE  = 6'd5;
    localparam logic [5:0] S_A_PS    = 6'd6;
    localparam logic [5:0] S_A_FIT   = 6'd7;
    localparam logic [5:0] S_A_SPL1  = 6'd8;
    localparam logic [5:0] S_A_SPL2  = 6'd9;
    localparam logic [5:0] S_A_EMIT  = 6'd10;
    localparam logic [5:0] S_SCAN    = 6'd11;
    localparam logic [5:0] S_NEW1    = 6'd12;
    localparam logic [5:0] S_NEW2    = 6'd13;
    localparam logic [5:0] S_F_CHK   = 6'd14;
    localparam logic [5:0] S_F_HEAD  = 6'd15;
    localparam logic [5:0] S_F_WALK  = 6'd16;
    localparam logic [5:0] S_F_NODE  = 6'd17;
    localparam logic [5:0] S_F_DEC   = 6'd18;
    localparam logic [5:0] S_F_MRG   = 6'd19;
    localparam logic [5:0] S_F_INS1  = 6'd20;
    localparam logic [5:0] S_F_INS2  = 6'd21;
    localparam logic [5:0] S_T_LIST  = 6'd22;
    localparam logic [5:0] S_T_HEAD  = 6'd23;
    localparam logic [5:0] S_T_WALK  = 6'd24;
    localparam logic [5:0] S_T_NODE  = 6'd25;
    localparam logic [5:0] S_T_REL   = 6'd26;
    localparam logic [5:0] S_T_NEXT  = 6'd27;
    localparam logic [5:0] S_T_END   = 6'd28;
    localparam logic [5:0] S_K1      = 6'd29;
    localparam logic [5:0] S_K2      = 6'd30;
    localparam logic [5:0] S_U1      = 6'd31;
    localparam logic [5:0] S_U2      = 6'd32;
    localparam logic [5:0] S_U3      = 6'd33;

    // control
    logic [5:0]     r_state, n_state, r_ret, n_ret;
    logic [ICW-1:0] r_init_cnt, n_init_cnt;
    logic [NW-1:0]  r_spare, n_spare;
    logic [CHUNKS-1:0] r_in_use, n_in_use;
    logic [LW-1:0]  r_owner [CHUNKS];
    logic [LW-1:0]  n_owner [CHUNKS];
    logic           r_out_valid, n_out_valid;
    logic [32:0]    r_chunk_size, n_chunk_size;
    logic           r_pend_v, n_pend_v;

    // payload
    t_req           r_req;
    t_rsp           r_out, n_out;
    logic [LW-1:0]  r_list, n_list;
    logic [NW-1:0]  r_head, n_head, r_n, n_n, r_np, n_np, r_nn, n_nn, r_m, n_m;
    logic [CW-1:0]  r_cidx, n_cidx, r_nchunk, n_nchunk, r_pend_chunk, n_pend_chunk;
    logic [31:0]    r_st, n_st, r_aoff, n_aoff, r_end, n_end;
    logic [32:0]    r_len, n_len, r_pad, n_pad, r_left, n_left;
    logic [40:0]    r_ps, n_ps;
    logic [NW-1:0]  r_p, n_p, r_pprev, n_pprev, r_q, n_q;
    logic           r_peq, n_peq, r_qeq, n_qeq;
    logic [31:0]    r_pstart, n_pstart, r_qstart, n_qstart, r_mstart, n_mstart;
    logic [32:0]    r_plen, n_plen, r_qlen, n_qlen, r_mlen, n_mlen;
    logic [NW-1:0]  r_un, n_un, r_up, n_up, r_uq, n_uq;

    // RAM ports
    logic [NW-1:0]  s_raddr;
    logic [LW-1:0]  s_hraddr;
    logic [CW-1:0]  rd_chunk;
    logic [31:0]    rd_start;
    logic [32:0]    rd_len;
    logic [NW-1:0]  rd_next, rd_prev, rd_head;
    logic           we_chunk, we_start, we_len, we_next, we_prev, we_head;
    logic [NW-1:0]  wa_chunk, wa_start, wa_len, wa_next, wa_prev;
    logic [LW-1:0]  wa_head;
    logic [CW-1:0]  wd_chunk;
    logic [31:0]    wd_start;
    logic [32:0]    wd_len;
    logic [NW-1:0]  wd_next, wd_prev, wd_head;

    // scratch
    logic [32:0] s_mask, s_left;
    logic        s_fit, s_qeq, s_pa, s_na;

    ffs_ram #(.WIDTH(CW), .DEPTH(NODES)) u_chunk (
        .i_clk(i_clk), .i_we(we_chunk), .i_waddr(wa_chunk[AW-1:0]), .i_wdata(wd_chunk),
        .i_raddr(s_raddr[AW-1:0]), .o_rdata(rd_chunk));
    ffs_ram #(.WIDTH(32), .DEPTH(NODES)) u_start (
        .i_clk(i_clk), .i_we(we_start), .i_waddr(wa_start[AW-1:0]), .i_wdata(wd_start),
        .i_raddr(s_raddr[AW-1:0]), .o_rdata(rd_start));
    ffs_ram #(.WIDTH(33), .DEPTH(NODES)) u_len (
        .i_clk(i_clk), .i_we(we_len), .i_waddr(wa_len[AW-1:0]), .i_wdata(wd_len),
        .i_raddr(s_raddr[AW-1:0]), .o_rdata(rd_len));
    ffs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (
        .i_clk(i_clk), .i_we(we_next), .i_waddr(wa_next[AW-1:0]), .i_wdata(wd_next),
        .i_raddr(s_raddr[AW-1:0]), .o_rdata(rd_next));
    ffs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev (
        .i_clk(i_clk), .i_we(we_prev), .i_waddr(wa_prev[AW-1:0]), .i_wdata(wd_prev),
        .i_raddr(s_raddr[AW-1:0]), .o_rdata(rd_prev));
    ffs_ram #(.WIDTH(NW), .DEPTH(LISTS)) u_head (
        .i_clk(i_clk), .i_we(we_head), .i_waddr(wa_head), .i_wdata(wd_head),
        .i_raddr(s_hraddr), .o_rdata(rd_head));

    always_comb begin
        case (r_state) inside
            S_F_WALK: s_raddr = r_q;
            S_K1:     s_raddr = r_spare;
            default:  s_raddr = r_n;
        endcase
        s_hraddr = (r_state == S_F_CHK) ? r_owner[r_cidx] : r_list;
    end

    always_comb begin
        n_chunk_size = r_chunk_size;
        if (i_cfg_we) begin
            if (i_cfg_wdata == 33'd0) begin
                n_chunk_size = 33'd1;
            end else if (i_cfg_wdata > CHUNK_SIZE_MAX) begin
                n_chunk_size = CHUNK_SIZE_MAX;
            end else begin
                n_chunk_size = i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_init_cnt = r_init_cnt;
        n_spare = r_spare;  n_in_use = r_in_use;  n_owner = r_owner;
        n_out_valid = 1'b0; n_out = r_out;  n_pend_v = r_pend_v;
        n_pend_chunk = r_pend_chunk;
        n_list = r_list; n_head = r_head; n_n = r_n; n_np = r_np; n_nn = r_nn;
        n_m = r_m; n_cidx = r_cidx; n_nchunk = r_nchunk; n_st = r_st; n_aoff = r_aoff;
        n_end = r_end; n_len = r_len; n_pad = r_pad; n_left = r_left; n_ps = r_ps;
        n_p = r_p; n_pprev = r_pprev; n_q = r_q; n_peq = r_peq; n_qeq = r_qeq;
        n_pstart = r_pstart;
        n_qstart = r_qstart; n_mstart = r_mstart; n_plen = r_plen; n_qlen = r_qlen;
        n_mlen = r_mlen; n_un = r_un; n_up = r_up; n_uq = r_uq;
        we_chunk = 1'b0; we_start = 1'b0; we_len = 1'b0;
        we_next = 1'b0; we_prev = 1'b0; we_head = 1'b0;
        wa_chunk = r_m; wa_start = r_n; wa_len = r_n; wa_next = r_n; wa_prev = r_n;
        wa_head = r_list;
        wd_chunk = r_nchunk; wd_start = r_end; wd_len = r_left;
        wd_next = NIL; wd_prev = NIL; wd_head = NIL;
        s_mask = (r_req.alignment == 33'd0) ? 33'd0 : r_req.alignment - 33'd1;
        s_fit  = (r_ps <= {8'd0, r_len});
        s_left = r_len - r_ps[32:0];
        s_qeq  = (rd_chunk == r_cidx);
        s_pa   = (r_p != NIL) && r_peq &&
                 ({2'b0, r_pstart} + {1'b0, r_plen} == {2'b0, r_req.block_offset});
        s_na   = (r_q != NIL) && r_qeq &&
                 ({9'd0, r_req.block_offset} + {1'b0, r_req.request_size}
                  == {9'd0, r_qstart});

        unique case (r_state)
            S_INIT: begin
                if (int'(r_init_cnt) < NODES) begin
                    we_next = 1'b1;  wa_next = NW'(r_init_cnt[AW-1:0]);
                    wd_next = NW'(int'(r_init_cnt) + 1);
                    we_prev = 1'b1;  wa_prev = NW'(r_init_cnt[AW-1:0]);
                    wd_prev = (r_init_cnt == '0) ? NIL : NW'(int'(r_init_cnt) - 1);
                end
                if (int'(r_init_cnt) < LISTS) begin
                    we_head = 1'b1;  wa_head = r_init_cnt[LW-1:0];
                end
                n_init_cnt = r_init_cnt + 1'b1;
                if (r_init_cnt == ICW'(IC - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (i_req.opcode)
                        OP_ALLOC: begin
                            n_list  = LW'(int'(i_req.resource_kind) * TYPES
                                          + int'(i_req.memory_type));
                            n_state = S_A_CHK;
                        end
                        OP_FREE: begin
                            n_cidx  = CW'(i_req.block_chunk);
                            n_state = S_F_CHK;
                        end
                        OP_TRIM: begin
                            n_list   = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_T_LIST;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_A_CHK: begin
                if (int'(r_req.memory_type) >= TYPES) begin
                    n_out = mk_rsp(ST_NOCHUNK, 5'd0, 32'd0, 1'b0, 1'b1);
                    n_out_valid = 1'b1;  n_state = S_IDLE;
                end else if (r_req.request_size >= {7'd0, r_chunk_size}) begin
                    n_out = mk_rsp(ST_DEDIC, 5'd0, 32'd0, 1'b0, 1'b1);
                    n_out_valid = 1'b1;  n_state = S_IDLE;
                end else begin
                    n_state = S_A_HEAD;
                end
            end
            S_A_HEAD: begin
                n_head = rd_head;  n_n = rd_head;  n_state = S_A_WALK;
            end
            S_A_WALK: begin
                if (r_n == NIL) begin
                    n_cidx = '0;  n_state = S_SCAN;
                end else begin
                    n_state = S_A_NODE;
                end
            end
            S_A_NODE: begin
                n_st = rd_start;  n_len = rd_len;  n_nchunk = rd_chunk;
                n_nn = rd_next;   n_np = rd_prev;
                n_pad = (r_req.alignment - ({1'b0, rd_start} & s_mask)) & s_mask;
                n_state = S_A_PS;
            end
            S_A_PS: begin
                n_ps   = {8'd0, r_pad} + {1'b0, r_req.request_size};
                n_aoff = r_st + r_pad[31:0];
                n_state = S_A_FIT;
            end
            S_A_FIT: begin
                n_left = s_left;
                n_end  = r_aoff + r_req.request_size[31:0];
                if (!s_fit) begin
                    n_n = r_nn;  n_state = S_A_WALK;
                end else if (r_pad != '0 && s_left != '0) begin
                    if (r_spare == NIL) begin
                        n_out = mk_rsp(ST_NONODE, 5'd0, 32'd0, 1'b0, 1'b1);
                        n_out_valid = 1'b1;  n_state = S_IDLE;
                    end else begin
                        n_ret = S_A_SPL1;  n_state = S_K1;
                    end
                end else if (r_pad != '0) begin
                    we_len = 1'b1;  wd_len = r_pad;
                    n_out = mk_rsp(ST_OK, 5'(r_nchunk), r_aoff, 1'b0, 1'b1);
                    n_out_valid = 1'b1;  n_state = S_IDLE;
                end else if (s_left != '0) begin
                    we_start = 1'b1;  wd_start = n_end;
                    we_len = 1'b1;    wd_len = s_left;
                    n_out = mk_rsp(ST_OK, 5'(r_nchunk), r_aoff, 1'b0, 1'b1);
                    n_out_valid = 1'b1;  n_state = S_IDLE;
                end else begin
                    n_un = r_n;  n_up = r_np;  n_uq = r_nn;
                    n_ret = S_A_EMIT;  n_state = S_U1;
                end
            end
            S_A_SPL1: begin
                we_chunk = 1'b1;  wa_chunk = r_m;  wd_chunk = r_nchunk;
                we_start = 1'b1;  wa_start = r_m;  wd_start = r_end;
                we_len = 1'b1;    wa_len = r_m;    wd_len = r_left;
                we_next = 1'b1;   wa_next = r_m;   wd_next = r_nn;
                we_prev = 1'b1;   wa_prev = r_m;   wd_prev = r_n;
                n_state = S_A_SPL2;
            end
            S_A_SPL2: begin
                we_len = 1'b1;   wa_len = r_n;   wd_len = r_pad;
                we_next = 1'b1;  wa_next = r_n;  wd_next = r_m;
                if (r_nn != NIL) begin
                    we_prev = 1'b1;  wa_prev = r_nn;  wd_prev = r_m;
                end
                n_out = mk_rsp(ST_OK, 5'(r_nchunk), r_aoff, 1'b0, 1'b1);
                n_out_valid = 1'b1;  n_state = S_IDLE;
            end
            S_A_EMIT: begin
                n_out = mk_rsp(ST_OK, 5'(r_nchunk), r_aoff, 1'b0, 1'b1);
                n_out_valid = 1'b1;  n_state = S_IDLE;
            end
            S_SCAN: begin
                if (!r_in_use[r_cidx]) begin
                    if (r_spare == NIL) begin
                        n_out = mk_rsp(ST_NONODE, 5'd0, 32'd0, 1'b0, 1'b1);
                        n_out_valid = 1'b1;  n_state = S_IDLE;
                    end else begin
                        n_ret = S_NEW1;  n_state = S_K1;
                    end
                end else if (r_cidx == CW'(CHUNKS - 1)) begin
                    n_out = mk_rsp(ST_NOCHUNK, 5'd0, 32'd0, 1'b0, 1'b1);
                    n_out_valid = 1'b1;  n_state = S_IDLE;
                end else begin
                    n_cidx = r_cidx + 1'b1;
                end
            end
            S_NEW1: begin
                n_in_use[r_cidx] = 1'b1;
                n_owner[r_cidx]  = r_list;
                we_chunk = 1'b1;  wa_chunk = r_m;  wd_chunk = r_cidx;
                we_start = 1'b1;  wa_start = r_m;  wd_start = r_req.request_size[31:0];
                we_len = 1'b1;    wa_len = r_m;
                wd_len = r_chunk_size - r_req.request_size[32:0];
                we_next = 1'b1;   wa_next = r_m;   wd_next = r_head;
                we_prev = 1'b1;   wa_prev = r_m;   wd_prev = NIL;
                n_state = S_NEW2;
            end
            S_NEW2: begin
                if (r_head != NIL) begin
                    we_prev = 1'b1;  wa_prev = r_head;  wd_prev = r_m;
                end
                we_head = 1'b1;  wd_head = r_m;
                n_out = mk_rsp(ST_OK, 5'(r_cidx), 32'd0, 1'b1, 1'b1);
                n_out_valid = 1'b1;  n_state = S_IDLE;
            end
            S_F_CHK: begin
                if (int'(r_req.block_chunk) >= CHUNKS || !r_in_use[r_cidx]) begin
                    n_out = mk_rsp(ST_NOTPOOL, 5'd0, 32'd0, 1'b0, 1'b1);
                    n_out_valid = 1'b1;  n_state = S_IDLE;
                end else begin
                    n_list = r_owner[r_cidx];
                    n_p = NIL;
                    n_state = S_F_HEAD;
                end
            end
            S_F_HEAD: begin
                n_q = rd_head;  n_state = S_F_WALK;
            end
            S_F_WALK: begin
                n_state = (r_q == NIL) ? S_F_DEC : S_F_NODE;
            end
            S_F_NODE: begin
                if ((r_p != NIL && r_peq && !s_qeq) ||
                    (s_qeq && rd_start > r_req.block_offset)) begin
                    n_qeq = s_qeq;  n_qstart = rd_start;  n_qlen = rd_len;
                    n_state = S_F_DEC;
                end else begin
                    n_p = r_q;  n_peq = s_qeq;  n_pstart = rd_start;  n_plen = rd_len;
                    n_pprev = rd_prev;  n_q = rd_next;
                    n_state = S_F_WALK;
                end
            end
            S_F_DEC: begin
                if (s_pa && s_na) begin
                    n_mstart = r_qstart - r_req.request_size[31:0] - r_plen[31:0];
                    n_mlen = r_qlen + r_req.request_size[32:0] + r_plen;
                    n_un = r_p;  n_up = r_pprev;  n_uq = r_q;
                    n_ret = S_F_MRG;  n_state = S_U1;
                end else if (s_pa) begin
                    we_len = 1'b1;  wa_len = r_p;
                    wd_len = r_plen + r_req.request_size[32:0];
                    n_out = mk_rsp(ST_OK, 5'd0, 32'd0, 1'b0, 1'b1);
                    n_out_valid = 1'b1;  n_state = S_IDLE;
                end else if (s_na) begin
                    we_start = 1'b1;  wa_start = r_q;
                    wd_start = r_qstart - r_req.request_size[31:0];
                    we_len = 1'b1;    wa_len = r_q;
                    wd_len = r_qlen + r_req.request_size[32:0];
                    n_out = mk_rsp(ST_OK, 5'd0, 32'd0, 1'b0, 1'b1);
                    n_out_valid = 1'b1;  n_state = S_IDLE;
                end else if (r_spare == NIL) begin
                    n_out = mk_rsp(ST_NONODE, 5'd0, 32'd0, 1'b0, 1'b1);
                    n_out_valid = 1'b1;  n_state = S_IDLE;
                end else begin
                    n_ret = S_F_INS1;  n_state = S_K1;
                end
            end
            S_F_MRG: begin
                we_start = 1'b1;  wa_start = r_q;  wd_start = r_mstart;
                we_len = 1'b1;    wa_len = r_q;    wd_len = r_mlen;
                n_out = mk_rsp(ST_OK, 5'd0, 32'd0, 1'b0, 1'b1);
                n_out_valid = 1'b1;  n_state = S_IDLE;
            end
            S_F_INS1: begin
                we_chunk = 1'b1;  wa_chunk = r_m;  wd_chunk = r_cidx;
                we_start = 1'b1;  wa_start = r_m;  wd_start = r_req.block_offset;
                we_len = 1'b1;    wa_len = r_m;    wd_len = r_req.request_size[32:0];
                we_next = 1'b1;   wa_next = r_m;   wd_next = r_q;
                we_prev = 1'b1;   wa_prev = r_m;   wd_prev = r_p;
                n_state = S_F_INS2;
            end
            S_F_INS2: begin
                if (r_p != NIL) begin
                    we_next = 1'b1;  wa_next = r_p;  wd_next = r_m;
                end else begin
                    we_head = 1'b1;  wd_head = r_m;
                end
                if (r_q != NIL) begin
                    we_prev = 1'b1;  wa_prev = r_q;  wd_prev = r_m;
                end
                n_out = mk_rsp(ST_OK, 5'd0, 32'd0, 1'b0, 1'b1);
                n_out_valid = 1'b1;  n_state = S_IDLE;
            end
            S_T_LIST: begin
                n_state = S_T_HEAD;
            end
            S_T_HEAD: begin
                n_n = rd_head;  n_state = S_T_WALK;
            end
            S_T_WALK: begin
                if (r_n != NIL) begin
                    n_state = S_T_NODE;
                end else if (r_list == LW'(LISTS - 1)) begin
                    n_state = S_T_END;
                end else begin
                    n_list = r_list + 1'b1;  n_state = S_T_LIST;
                end
            end
            S_T_NODE: begin
                n_nn = rd_next;  n_np = rd_prev;  n_cidx = rd_chunk;
                if (rd_len != r_chunk_size) begin
                    n_n = rd_next;  n_state = S_T_WALK;
                end else begin
                    n_state = S_T_REL;
                end
            end
            S_T_REL: begin
                // hold each release one step so the final one can carry last
                if (r_in_use[r_cidx]) begin
                    n_in_use[r_cidx] = 1'b0;
                    n_owner[r_cidx]  = '0;
                    if (r_pend_v) begin
                        n_out = mk_rsp(ST_REL, 5'(r_pend_chunk), 32'd0, 1'b0, 1'b0);
                        n_out_valid = 1'b1;
                    end
                    n_pend_v = 1'b1;
                    n_pend_chunk = r_cidx;
                end
                n_un = r_n;  n_up = r_np;  n_uq = r_nn;
                n_ret = S_T_NEXT;  n_state = S_U1;
            end
            S_T_NEXT: begin
                n_n = r_nn;  n_state = S_T_WALK;
            end
            S_T_END: begin
                if (r_pend_v) begin
                    n_out = mk_rsp(ST_REL, 5'(r_pend_chunk), 32'd0, 1'b0, 1'b1);
                end else begin
                    n_out = mk_rsp(ST_NOREL, 5'd0, 32'd0, 1'b0, 1'b1);
                end
                n_out_valid = 1'b1;  n_state = S_IDLE;
            end
            S_K1: begin
                n_state = S_K2;
            end
            S_K2: begin
                n_m = r_spare;
                n_spare = rd_next;
                if (rd_next != NIL) begin
                    we_prev = 1'b1;  wa_prev = rd_next;  wd_prev = NIL;
                end
                n_state = r_ret;
            end
            S_U1: begin
                if (r_up != NIL) begin
                    we_next = 1'b1;  wa_next = r_up;  wd_next = r_uq;
                end else begin
                    we_head = 1'b1;  wd_head = r_uq;
                end
                if (r_uq != NIL) begin
                    we_prev = 1'b1;  wa_prev = r_uq;  wd_prev = r_up;
                end
                n_state = S_U2;
            end
            S_U2: begin
                we_next = 1'b1;  wa_next = r_un;  wd_next = r_spare;
                we_prev = 1'b1;  wa_prev = r_un;  wd_prev = NIL;
                n_state = S_U3;
            end
            S_U3: begin
                if (r_spare != NIL) begin
                    we_prev = 1'b1;  wa_prev = r_spare;  wd_prev = r_un;
                end
                n_spare = r_un;
                n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_ret        <= S_IDLE;
            r_init_cnt   <= '0;
            r_spare      <= '0;
            r_in_use     <= '0;
            r_out_valid  <= 1'b0;
            r_chunk_size <= CHUNK_SIZE_RST;
            r_pend_v     <= 1'b0;
            for (int i = 0; i < CHUNKS; i++) begin
                r_owner[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_init_cnt   <= n_init_cnt;
            r_spare      <= n_spare;
            r_in_use     <= n_in_use;
            r_out_valid  <= n_out_valid;
            r_chunk_size <= n_chunk_size;
            r_pend_v     <= n_pend_v;
            r_owner      <= n_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_req <= i_req;
        end
        r_out <= n_out;  r_list <= n_list;  r_head <= n_head;  r_n <= n_n;
        r_np <= n_np;  r_nn <= n_nn;  r_m <= n_m;  r_cidx <= n_cidx;
        r_nchunk <= n_nchunk;  r_pend_chunk <= n_pend_chunk;  r_st <= n_st;
        r_aoff <= n_aoff;  r_end <= n_end;  r_len <= n_len;  r_pad <= n_pad;
        r_left <= n_left;  r_ps <= n_ps;  r_p <= n_p;  r_pprev <= n_pprev;
        r_q <= n_q;  r_peq <= n_peq;  r_qeq <= n_qeq;  r_pstart <= n_pstart;
        r_qstart <= n_qstart;  r_mstart <= n_mstart;  r_plen <= n_plen;
        r_qlen <= n_qlen;  r_mlen <= n_mlen;  r_un <= n_un;  r_up <= n_up;
        r_uq <= n_uq;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // only a trim can leave more results pending
    a_nonlast_is_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last) |-> (o_result.status == ST_REL))
        else $error("non-final result that is not a chunk release");

    a_last_frees_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last) |-> !o_busy)
        else $error("final result shown while still busy");

    a_take_has_spare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_K1) |-> (r_spare != NIL))
        else $error("spare node taken from an empty spare list");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req.opcode == OP_ALLOC || i_req.opcode == OP_FREE ||
         i_req.opcode == OP_TRIM)) |=> (o_busy && !o_result_valid))
        else $error("accepted item did not start work");

    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_result_valid)
        else $error("result during clearing pass");

endmodule
